// ----- rtl/b2da_pkg.sv -----
// Package for the binary to decimal ASCII converter.
// Holds widths, constants and the controller/datapath command and status types.
// No dependencies.
`default_nettype none

package b2da_pkg;

  localparam int unsigned VALUE_W    = 31;
  localparam int unsigned VALUE_BITS = 31;
  localparam int unsigned MIN_W      = 4;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned BCD_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
  localparam int unsigned IDX_W      = 4;
  localparam int unsigned STEP_W     = $clog2(VALUE_BITS + 1);

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

  typedef struct packed {
    logic load;
    logic shift;
    logic prep;
    logic emit;
  } b2da_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic out_free;
    logic emit_last;
  } b2da_stat_t;

endpackage

`default_nettype wire

// ----- rtl/b2da_in_if.sv -----
// Input channel interface: valid/ready handshake with the integer and minimum width.
// Depends on b2da_pkg.
`default_nettype none

interface b2da_in_if;
  logic                          valid;
  logic                          ready;
  logic [b2da_pkg::VALUE_W-1:0]  value;
  logic [b2da_pkg::MIN_W-1:0]    min_digits;

  modport source (output valid, output value, output min_digits, input ready);
  modport sink (input valid, input value, input min_digits, output ready);
endinterface

`default_nettype wire

// ----- rtl/b2da_out_if.sv -----
// Output channel interface: valid/ready handshake with one ASCII digit per beat.
// Depends on b2da_pkg.
`default_nettype none

interface b2da_out_if;
  logic                         valid;
  logic                         ready;
  logic [b2da_pkg::CHAR_W-1:0]  digit_char;
  logic                         last;

  modport source (output valid, output digit_char, output last, input ready);
  modport sink (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

// ----- rtl/b2da_ctrl.sv -----
// Controller state machine: sequences load, double-dabble shifts, length setup and emission.
// Depends on b2da_pkg.
`default_nettype none

module b2da_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire b2da_pkg::b2da_stat_t stat_i,
  output b2da_pkg::b2da_cmd_t       cmd_o
);
  import b2da_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_PREP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.shift = 1'b1;
        if (stat_i.conv_done) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/b2da_dp.sv -----
// Datapath: shift-and-add-3 BCD converter, digit index and the output register.
// Depends on b2da_pkg.
`default_nettype none

module b2da_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire b2da_pkg::b2da_cmd_t          cmd_i,
  output b2da_pkg::b2da_stat_t              stat_o,
  input  wire logic [b2da_pkg::VALUE_W-1:0] value_i,
  input  wire logic [b2da_pkg::MIN_W-1:0]   min_digits_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [b2da_pkg::CHAR_W-1:0]       out_char_o,
  output logic                              out_last_o
);
  import b2da_pkg::*;

  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]      bcd_q, bcd_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [MIN_W-1:0]      min_q, min_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]     out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  logic [3:0]       digits [BCD_DIGITS];
  logic [BCD_W-1:0] dabbled;
  logic [IDX_W-1:0] top_idx;
  logic [IDX_W-1:0] min_idx;
  logic [3:0]       cur_digit;

  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      digits[i]           = bcd_q[4*i +: 4];
      dabbled[4*i +: 4]   = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                       : bcd_q[4*i +: 4];
    end
  end

  always_comb begin
    top_idx = '0;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        top_idx = IDX_W'(i);
      end
    end
    min_idx = (min_q == '0) ? '0 : IDX_W'(min_q - MIN_W'(1));
  end

  assign cur_digit = (idx_q < IDX_W'(BCD_DIGITS)) ? digits[idx_q] : 4'd0;

  always_comb begin
    bin_d       = bin_q;
    bcd_d       = bcd_q;
    step_d      = step_q;
    min_d       = min_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    if (cmd_i.load) begin
      bin_d  = VALUE_BITS'(value_i);
      bcd_d  = '0;
      step_d = STEP_W'(VALUE_BITS);
      min_d  = min_digits_i;
    end
    if (cmd_i.shift) begin
      bcd_d  = {dabbled[BCD_W-2:0], bin_q[VALUE_BITS-1]};
      bin_d  = {bin_q[VALUE_BITS-2:0], 1'b0};
      step_d = step_q - STEP_W'(1);
    end
    if (cmd_i.prep) begin
      idx_d = (top_idx > min_idx) ? top_idx : min_idx;
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      out_char_d  = ASCII_ZERO + {2'b00, cur_digit};
      out_last_d  = (idx_q == '0);
      idx_d       = idx_q - IDX_W'(1);
    end
  end

  assign stat_o.conv_done = (step_q == STEP_W'(1));
  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.emit_last = (idx_q == '0);

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    step_q     <= step_d;
    min_q      <= min_d;
    idx_q      <= idx_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

endmodule

`default_nettype wire

// ----- rtl/binary_to_decimal_ascii.sv -----
// Binary to decimal ASCII converter, top level. An item is accepted, then shifted bit by bit
// through the double-dabble loop in the BCD datapath, then its length is set up,
// then its characters (1 to 15) are emitted one per cycle while the output is free.
// The first character follows the input beat once the shift loop and the length setup are done.
// Reset is asynchronous and active low; it empties the output register and idles the FSM.
`default_nettype none

module binary_to_decimal_ascii (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  b2da_in_if.sink    in_i,
  b2da_out_if.source out_o
);
  import b2da_pkg::*;

  b2da_cmd_t  cmd;
  b2da_stat_t stat;
  logic       in_ready;

  b2da_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  b2da_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .value_i      (in_i.value),
    .min_digits_i (in_i.min_digits),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_char_o   (out_o.digit_char),
    .out_last_o   (out_o.last)
  );

  assign in_i.ready = in_ready;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("input accepted while a conversion was in progress");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.digit_char >= 6'd48 && out_o.digit_char <= 6'd57))
    else $error("output character is not a decimal digit");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_i.ready) |-> out_o.valid && out_o.last)
    else $error("converter went idle without a final character");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_binary_to_decimal_ascii.sv -----
// Self-checking testbench for binary_to_decimal_ascii: it drives numbers with minimum widths
// and checks every ASCII digit beat against its own decimal conversion.
// Depends on b2da_pkg, b2da_in_if, b2da_out_if and the binary_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module tb_binary_to_decimal_ascii;
  import b2da_pkg::*;

  localparam int unsigned DIGIT_BASE = 10;
  localparam int unsigned MAX_CHARS  = 15;
  localparam int unsigned RANDOM_PER_MIX = 90;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct {
    logic [VALUE_W-1:0] value;
    logic [MIN_W-1:0]   min_digits;
  } number_req_t;

  typedef struct {
    logic [CHAR_W-1:0] digit_char;
    logic              last;
  } ascii_beat_t;

  logic clk_i;
  logic rst_ni;

  b2da_in_if  in_if ();
  b2da_out_if out_if ();

  binary_to_decimal_ascii DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  number_req_t numbers_to_send[$];
  ascii_beat_t expected_digits[$];

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  logic        hold_go;
  logic        hold_off;
  logic        number_taken;
  int unsigned error_count;
  int unsigned numbers_accepted;
  int unsigned digits_checked;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Decimal text of one number, most significant digit first, zero-padded to the minimum.
  task automatic predict_decimal_text(input logic [VALUE_W-1:0] value,
                                      input logic [MIN_W-1:0] min_digits);
    logic [CHAR_W-1:0] reversed [MAX_CHARS];
    longint unsigned   remaining;
    int unsigned       width;
    int unsigned       count;
    ascii_beat_t       beat;
    remaining = longint'(value) & ((64'd1 << VALUE_BITS) - 1);
    width = (min_digits > MAX_CHARS) ? MAX_CHARS : min_digits;
    count = 0;
    do begin
      reversed[count] = ASCII_ZERO + CHAR_W'(remaining % DIGIT_BASE);
      remaining = remaining / DIGIT_BASE;
      count++;
    end while (remaining != 0 && count < MAX_CHARS);
    while (count < width) begin
      reversed[count] = ASCII_ZERO;
      count++;
    end
    for (int k = 0; k < count; k++) begin
      beat.digit_char = reversed[count - 1 - k];
      beat.last = (k + 1 == count);
      expected_digits.push_back(beat);
    end
  endtask

  task automatic queue_number(input longint unsigned value, input int unsigned min_digits);
    number_req_t req;
    req.value = VALUE_W'(value);
    req.min_digits = MIN_W'(min_digits);
    numbers_to_send.push_back(req);
  endtask

  task automatic wait_until_sent();
    while (numbers_to_send.size() != 0) @(posedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !number_taken) begin
      in_if.valid <= 1'b1;
    end else if (numbers_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
      in_if.valid      <= 1'b1;
      in_if.value      <= numbers_to_send[0].value;
      in_if.min_digits <= numbers_to_send[0].min_digits;
    end else begin
      in_if.valid      <= 1'b0;
      in_if.value      <= VALUE_W'($urandom);
      in_if.min_digits <= MIN_W'($urandom);
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= rst_ni && !hold_off && ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk_i) begin
    number_taken <= rst_ni && in_if.valid && in_if.ready;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        predict_decimal_text(in_if.value, in_if.min_digits);
        void'(numbers_to_send.pop_front());
        numbers_accepted++;
      end
      if (out_if.valid && out_if.ready) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected beat: digit_char %0d last %0b", out_if.digit_char, out_if.last);
          error_count++;
        end else begin
          if (out_if.digit_char !== expected_digits[0].digit_char) begin
            $error("digit_char: expected %0d, actual %0d",
                   expected_digits[0].digit_char, out_if.digit_char);
            error_count++;
          end
          if (out_if.last !== expected_digits[0].last) begin
            $error("last: expected %0b, actual %0b", expected_digits[0].last, out_if.last);
            error_count++;
          end
          void'(expected_digits.pop_front());
          digits_checked++;
        end
      end
    end
  end

  // The output side goes quiet for a long stretch so that the converter backs up.
  initial begin
    hold_off = 1'b0;
    wait (hold_go === 1'b1);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    longint unsigned upper;
    longint unsigned lower;
    int unsigned     digits;
    rst_ni = 1'b0;
    hold_go = 1'b0;
    number_taken = 1'b0;
    error_count = 0;
    numbers_accepted = 0;
    digits_checked = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    in_if.valid = 1'b0;
    in_if.value = '0;
    in_if.min_digits = '0;
    out_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_number(0, 0);
    queue_number(0, 1);
    queue_number(0, 15);
    queue_number(5, 0);
    queue_number(9, 1);
    queue_number(10, 0);
    queue_number(99, 2);
    queue_number(100, 3);
    queue_number(1000, 4);
    queue_number(7, 3);
    queue_number(42, 8);
    queue_number(12345, 10);
    queue_number(1, 15);
    queue_number(999999999, 0);
    queue_number(1000000000, 0);
    queue_number(1073741824, 5);
    queue_number(32'h2AAA_AAAA, 7);
    queue_number(32'h5555_5555 & 32'h7FFF_FFFF, 14);
    queue_number(2147483647, 0);
    queue_number(2147483647, 15);
    wait_until_sent();

    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 72;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 72;
        end
        default: begin
          sender_idle_pct = 30;
          receiver_stall_pct = 30;
        end
      endcase
      for (int n = 0; n < RANDOM_PER_MIX; n++) begin
        if ($urandom_range(3) == 0) begin
          queue_number($urandom & 32'h7FFF_FFFF, $urandom_range(15));
        end else begin
          digits = $urandom_range(1, 10);
          lower = (digits == 1) ? 0 : 10 ** (digits - 1);
          upper = 10 ** digits - 1;
          if (upper > 64'h7FFF_FFFF) upper = 64'h7FFF_FFFF;
          queue_number(lower + ($urandom % (upper - lower + 1)), $urandom_range(15));
        end
      end
      if (mix == 0) begin
        @(posedge clk_i);
        hold_go = 1'b1;
      end
      wait_until_sent();
    end

    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers into %0d checked digit beats under four idle/stall mixes,",
             numbers_accepted, digits_checked);
    $display("including a %0d-cycle output hold-off with the input kept busy.", HOLD_CYCLES);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/b2da_pkg.sv
rtl/b2da_in_if.sv
rtl/b2da_out_if.sv
rtl/b2da_ctrl.sv
rtl/b2da_dp.sv
rtl/binary_to_decimal_ascii.sv
tb/tb_binary_to_decimal_ascii.sv
